// ===== rtl/core/rhd_pkg.sv =====
`default_nettype none

package rhd_pkg;

   localparam logic [7:0] REPEAT_BIAS = 8'd29;
   localparam logic [7:0] STAR_CHAR   = 8'h2A;
   localparam logic [7:0] TILDE_CHAR  = 8'h7E;
   localparam int unsigned REPEAT_WIDTH = 7;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_COUNT = 2'd1,
      ST_BAD_HEX   = 2'd2,
      ST_ODD       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_CHECK,
      SEQ_TAIL_HELD,
      SEQ_TAIL_STAR,
      SEQ_STATUS
   } seq_state_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_status;
      logic [1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Control from the sequencer to the nibble unit.
   typedef struct packed {
      logic       feed;
      logic [7:0] feed_char;
      logic       set_bad_count;
      logic       clear;
   } nib_ctrl_type;

   // State of the nibble unit seen by the sequencer.
   typedef struct packed {
      status_type error_code;
      logic       nibble_valid;
   } nib_status_type;

   function automatic digit_type hex_digit(input logic [7:0] ch);
      digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d.value = 4'(ch - 8'h30);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         d.value = 4'(ch - 8'h37);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         d.value = 4'(ch - 8'h57);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rhd_nibble_unit.sv =====
`default_nettype none

module rhd_nibble_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire rhd_pkg::nib_ctrl_type ctrl,
   output rhd_pkg::nib_status_type  nib_status,
   output logic                     byte_valid,
   output logic [7:0]               byte_value
);

   logic [3:0]          high_nibble_ff, high_nibble_in;
   logic                nibble_valid_ff, nibble_valid_in;
   rhd_pkg::status_type error_ff, error_in;
   rhd_pkg::digit_type  dig;

   always_comb begin
      dig             = rhd_pkg::hex_digit(ctrl.feed_char);
      high_nibble_in  = high_nibble_ff;
      nibble_valid_in = nibble_valid_ff;
      error_in        = error_ff;
      byte_valid      = 1'b0;
      byte_value      = {high_nibble_ff, dig.value};
      if (ctrl.clear) begin
         high_nibble_in  = 4'd0;
         nibble_valid_in = 1'b0;
         error_in        = rhd_pkg::ST_OK;
      end else if (ctrl.set_bad_count) begin
         error_in = rhd_pkg::ST_BAD_COUNT;
      end else if (ctrl.feed && error_ff != rhd_pkg::ST_BAD_COUNT) begin
         if (error_ff != rhd_pkg::ST_OK || !dig.valid) begin
            // After a bad digit only the parity of the digit count is kept.
            if (error_ff == rhd_pkg::ST_OK) begin
               error_in = rhd_pkg::ST_BAD_HEX;
            end
            nibble_valid_in = !nibble_valid_ff;
         end else if (nibble_valid_ff) begin
            byte_valid      = 1'b1;
            nibble_valid_in = 1'b0;
         end else begin
            high_nibble_in  = dig.value;
            nibble_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_valid_ff <= 1'b0;
         error_ff        <= rhd_pkg::ST_OK;
      end else begin
         nibble_valid_ff <= nibble_valid_in;
         error_ff        <= error_in;
      end
      high_nibble_ff <= high_nibble_in;
   end

   assign nib_status.error_code   = error_ff;
   assign nib_status.nibble_valid = nibble_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rhd_out_reg.sv =====
`default_nettype none

module rhd_out_reg (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       load,
   input  wire rhd_pkg::rsp_payload_type load_data,
   output logic                      load_ready,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output rhd_pkg::rsp_payload_type  rsp_data
);

   logic                     valid_ff, valid_in;
   rhd_pkg::rsp_payload_type data_ff, data_in;

   always_comb begin
      load_ready = !valid_ff || !rsp_stall;
      valid_in   = valid_ff && rsp_stall;
      data_in    = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rle_hex_payload_decoder.sv =====
// A digit is held until the next character is taken; the first byte word that this releases
// passes through the sequencer state register and then the output register before it leaves.
// A character that feeds k digits to the nibble unit (k up to 98 for a run) holds req_stall
// high while they are fed and through the check state; the nibble unit takes one digit per
// cycle when rsp is free. With last_char set, up to two tail digits and the status word follow.
// Reset (synchronous, active high) empties the output register and clears all payload state.
`default_nettype none

module rle_hex_payload_decoder (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire rhd_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output rhd_pkg::rsp_payload_type  rsp_data
);

   rhd_pkg::seq_state_type state_ff, state_in;
   logic [7:0]  held_char_ff, held_char_in;
   logic        held_valid_ff, held_valid_in;
   logic        awaiting_ff, awaiting_in;
   logic [7:0]  feed_char_ff, feed_char_in;
   logic [rhd_pkg::REPEAT_WIDTH-1:0] repeats_ff, repeats_in;
   logic        last_ff, last_in;

   rhd_pkg::nib_ctrl_type    ctrl;
   rhd_pkg::nib_status_type  nib_status;
   rhd_pkg::rsp_payload_type load_data;
   rhd_pkg::status_type      final_status;
   logic        byte_valid;
   logic [7:0]  byte_value;
   logic        load, load_ready, accept, emit_status;
   logic [7:0]  count_full;

   assign req_stall = (state_ff != rhd_pkg::SEQ_IDLE);
   assign accept    = req_valid && !req_stall;
   assign count_full = req_data.character - (rhd_pkg::REPEAT_BIAS - 8'd1);

   always_comb begin
      if (nib_status.error_code == rhd_pkg::ST_BAD_COUNT) begin
         final_status = rhd_pkg::ST_BAD_COUNT;
      end else if (nib_status.nibble_valid) begin
         final_status = rhd_pkg::ST_ODD;
      end else if (nib_status.error_code == rhd_pkg::ST_BAD_HEX) begin
         final_status = rhd_pkg::ST_BAD_HEX;
      end else begin
         final_status = rhd_pkg::ST_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      awaiting_in   = awaiting_ff;
      feed_char_in  = feed_char_ff;
      repeats_in    = repeats_ff;
      last_in       = last_ff;
      ctrl.feed          = 1'b0;
      ctrl.feed_char     = feed_char_ff;
      ctrl.set_bad_count = 1'b0;
      ctrl.clear         = 1'b0;
      emit_status        = 1'b0;
      case (state_ff)
         rhd_pkg::SEQ_IDLE: begin
            if (accept) begin
               last_in  = req_data.last_char;
               state_in = rhd_pkg::SEQ_CHECK;
               if (nib_status.error_code == rhd_pkg::ST_BAD_COUNT) begin
                  state_in = rhd_pkg::SEQ_CHECK;
               end else if (awaiting_ff) begin
                  awaiting_in   = 1'b0;
                  held_valid_in = 1'b0;
                  if (req_data.character <= rhd_pkg::REPEAT_BIAS ||
                      req_data.character > rhd_pkg::TILDE_CHAR) begin
                     ctrl.set_bad_count = 1'b1;
                  end else begin
                     // The held character once, then N minus the bias copies.
                     feed_char_in = held_char_ff;
                     repeats_in   = count_full[rhd_pkg::REPEAT_WIDTH-1:0];
                     state_in     = rhd_pkg::SEQ_RUN;
                  end
               end else if (req_data.character == rhd_pkg::STAR_CHAR && held_valid_ff) begin
                  awaiting_in = 1'b1;
               end else begin
                  if (held_valid_ff) begin
                     feed_char_in = held_char_ff;
                     repeats_in   = rhd_pkg::REPEAT_WIDTH'(1);
                     state_in     = rhd_pkg::SEQ_RUN;
                  end
                  held_char_in  = req_data.character;
                  held_valid_in = 1'b1;
               end
            end
         end
         rhd_pkg::SEQ_RUN: begin
            if (load_ready) begin
               ctrl.feed  = 1'b1;
               repeats_in = repeats_ff - rhd_pkg::REPEAT_WIDTH'(1);
               if (repeats_ff == rhd_pkg::REPEAT_WIDTH'(1)) begin
                  state_in = rhd_pkg::SEQ_CHECK;
               end
            end
         end
         rhd_pkg::SEQ_CHECK: begin
            if (!last_ff) begin
               state_in = rhd_pkg::SEQ_IDLE;
            end else if (nib_status.error_code == rhd_pkg::ST_BAD_COUNT) begin
               state_in = rhd_pkg::SEQ_STATUS;
            end else if (held_valid_ff) begin
               state_in = rhd_pkg::SEQ_TAIL_HELD;
            end else if (awaiting_ff) begin
               state_in = rhd_pkg::SEQ_TAIL_STAR;
            end else begin
               state_in = rhd_pkg::SEQ_STATUS;
            end
         end
         rhd_pkg::SEQ_TAIL_HELD: begin
            ctrl.feed_char = held_char_ff;
            if (load_ready) begin
               ctrl.feed = 1'b1;
               state_in  = awaiting_ff ? rhd_pkg::SEQ_TAIL_STAR : rhd_pkg::SEQ_STATUS;
            end
         end
         rhd_pkg::SEQ_TAIL_STAR: begin
            // A group cut short by the end of the payload: the star is a plain character.
            ctrl.feed_char = rhd_pkg::STAR_CHAR;
            if (load_ready) begin
               ctrl.feed = 1'b1;
               state_in  = rhd_pkg::SEQ_STATUS;
            end
         end
         rhd_pkg::SEQ_STATUS: begin
            if (load_ready) begin
               emit_status   = 1'b1;
               ctrl.clear    = 1'b1;
               held_valid_in = 1'b0;
               awaiting_in   = 1'b0;
               held_char_in  = 8'd0;
               state_in      = rhd_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = rhd_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      load = byte_valid || emit_status;
      load_data.data_byte = emit_status ? 8'd0 : byte_value;
      load_data.is_status = emit_status;
      load_data.status    = emit_status ? final_status : rhd_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rhd_pkg::SEQ_IDLE;
         held_valid_ff <= 1'b0;
         awaiting_ff   <= 1'b0;
         repeats_ff    <= '0;
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         awaiting_ff   <= awaiting_in;
         repeats_ff    <= repeats_in;
         last_ff       <= last_in;
      end
      held_char_ff <= held_char_in;
      feed_char_ff <= feed_char_in;
   end

   rhd_nibble_unit u_nibble (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .nib_status (nib_status),
      .byte_valid (byte_valid),
      .byte_value (byte_value)
   );

   rhd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_data  (load_data),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // A pending repeat count always belongs to a held character.
   a_await_held: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> held_valid_ff)
      else $error("awaiting a count with no held character");

   // Once a bad count is seen no further byte word may be produced.
   a_no_byte_after_bad_count: assert property (@(posedge clock) disable iff (reset)
      nib_status.error_code == rhd_pkg::ST_BAD_COUNT |-> !byte_valid)
      else $error("byte produced after a bad repeat count");

   // The run counter never sits at zero while a run is being expanded.
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == rhd_pkg::SEQ_RUN |-> repeats_ff != '0)
      else $error("run state with an empty repeat count");

   // Sending the status word leaves the decoder clean for the next payload.
   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rhd_pkg::SEQ_STATUS && load_ready) |=>
         (state_ff == rhd_pkg::SEQ_IDLE && !held_valid_ff && !awaiting_ff &&
          !nib_status.nibble_valid && nib_status.error_code == rhd_pkg::ST_OK))
      else $error("state not cleared after the status word");

endmodule

`default_nettype wire

// ===== tb/tb_rle_hex_payload_decoder.sv =====
`timescale 1ns / 1ps

module tb_rle_hex_payload_decoder;

   localparam int QUIET_LIMIT = 3000;
   localparam int MAX_GAP     = 24;
   localparam int DRAIN_CYCLES = 12;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   rhd_pkg::req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rhd_pkg::rsp_payload_type rsp_data;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int chars_sent = 0;
   int payloads_sent = 0;
   int bytes_checked = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   // Decoder state as the predictor sees it.
   logic [7:0] held_char;
   logic       held_ok;
   logic       want_count;
   logic [3:0] high_digit;
   logic       half_pair;
   rhd_pkg::status_type first_error;

   rhd_pkg::rsp_payload_type expected_words [$];
   rhd_pkg::rsp_payload_type got_word;
   rhd_pkg::rsp_payload_type want_word;
   logic [7:0]      payload_chars [$];

   rle_hex_payload_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function void clear_payload_state();
      held_char   = '0;
      held_ok     = 1'b0;
      want_count  = 1'b0;
      high_digit  = '0;
      half_pair   = 1'b0;
      first_error = rhd_pkg::ST_OK;
   endfunction

   function void push_word(input logic [7:0] b, input logic is_st,
                           input rhd_pkg::status_type st);
      rhd_pkg::rsp_payload_type r;
      r.data_byte = b;
      r.is_status = is_st;
      r.status    = st;
      expected_words.insert(expected_words.size(), r);
   endfunction

   // One character of the expanded stream goes into the hex pairing.
   function void pair_digit(input logic [7:0] c);
      int v;
      if (first_error == rhd_pkg::ST_BAD_COUNT) return;
      v = digit_of(c);
      if (first_error != rhd_pkg::ST_OK || v < 0) begin
         // Parity is still tracked after a hex error so that an odd count wins.
         if (first_error == rhd_pkg::ST_OK) first_error = rhd_pkg::ST_BAD_HEX;
         half_pair = !half_pair;
         return;
      end
      if (half_pair) begin
         push_word({high_digit, v[3:0]}, 1'b0, rhd_pkg::ST_OK);
         half_pair = 1'b0;
      end else begin
         high_digit = v[3:0];
         half_pair  = 1'b1;
      end
   endfunction

   function void predict_char(input rhd_pkg::req_payload_type w);
      int copies;
      rhd_pkg::status_type st;
      if (first_error != rhd_pkg::ST_BAD_COUNT) begin
         if (want_count) begin
            want_count = 1'b0;
            if (w.character <= rhd_pkg::REPEAT_BIAS || w.character > rhd_pkg::TILDE_CHAR) begin
               first_error = rhd_pkg::ST_BAD_COUNT;
            end else begin
               copies = int'(w.character) - int'(rhd_pkg::REPEAT_BIAS);
               pair_digit(held_char);
               repeat (copies) pair_digit(held_char);
            end
            held_ok = 1'b0;
         end else if (w.character == rhd_pkg::STAR_CHAR && held_ok) begin
            want_count = 1'b1;
         end else begin
            if (held_ok) pair_digit(held_char);
            held_char = w.character;
            held_ok   = 1'b1;
         end
      end
      if (w.last_char) begin
         // A group cut short at the end is read as plain characters.
         if (first_error != rhd_pkg::ST_BAD_COUNT) begin
            if (held_ok) pair_digit(held_char);
            if (want_count) pair_digit(rhd_pkg::STAR_CHAR);
         end
         if (first_error == rhd_pkg::ST_BAD_COUNT) st = rhd_pkg::ST_BAD_COUNT;
         else if (half_pair) st = rhd_pkg::ST_ODD;
         else if (first_error == rhd_pkg::ST_BAD_HEX) st = rhd_pkg::ST_BAD_HEX;
         else st = rhd_pkg::ST_OK;
         push_word(8'h00, 1'b1, st);
         clear_payload_state();
      end
   endfunction

   task report_mismatch(input string what, input rhd_pkg::rsp_payload_type got,
                        input rhd_pkg::rsp_payload_type want);
      mismatches++;
      $display("[%0t] mismatch, %s: got %02h/%0d/%0d, wanted %02h/%0d/%0d",
               $time, what, got.data_byte, got.is_status, got.status,
               want.data_byte, want.is_status, want.status);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word = rsp_data;
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected", got_word, '0);
         end else begin
            want_word = expected_words.pop_front();
            if (got_word.data_byte !== want_word.data_byte ||
                got_word.is_status !== want_word.is_status ||
                got_word.status !== want_word.status) begin
               report_mismatch("wrong field", got_word, want_word);
            end
            if (want_word.is_status) status_seen[want_word.status]++;
            else bytes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   task send_char(input logic [7:0] c, input logic last);
      int gap;
      rhd_pkg::req_payload_type w;
      gap = 0;
      w.character = c;
      w.last_char = last;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predict_char(w);
      chars_sent++;
      if (last) payloads_sent++;
   endtask

   task send_text(input string s, input logic last);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i], last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] random_digit();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   task test_hex_pairs();
      send_text("00Ff", 1'b1);
   endtask

   task test_runs();
      send_text("f*\"", 1'b1);
      // The largest count expands to 98 digits.
      send_text("a*~", 1'b1);
   endtask

   task test_bad_count();
      send_text("1*", 1'b0);
      send_char(rhd_pkg::REPEAT_BIAS, 1'b0);
      send_char("Z", 1'b1);
      send_text("3*", 1'b0);
      send_char(rhd_pkg::TILDE_CHAR + 8'd1, 1'b1);
   endtask

   task test_bad_hex();
      send_text("g0", 1'b1);
      // A star with nothing held is an ordinary character.
      send_text("*", 1'b1);
      // A group cut short by the end of the payload.
      send_text("5*", 1'b1);
   endtask

   task test_random(input int idle, input int stall, input int item_goal);
      int sent;
      int groups;
      int digits;
      int count;
      int i;
      int pick;
      idle_pct  = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < item_goal) begin
         payload_chars.delete();
         digits = 0;
         groups = $urandom_range(1, 8);
         for (i = 0; i < groups; i++) begin
            if ($urandom_range(99) < 60) begin
               payload_chars.insert(payload_chars.size(), random_digit());
               digits++;
            end else begin
               count = ($urandom_range(9) == 0) ? $urandom_range(30, 126)
                                                : $urandom_range(30, 36);
               payload_chars.insert(payload_chars.size(), random_digit());
               payload_chars.insert(payload_chars.size(), rhd_pkg::STAR_CHAR);
               payload_chars.insert(payload_chars.size(), count[7:0]);
               digits += 1 + count - int'(rhd_pkg::REPEAT_BIAS);
            end
         end
         if (digits % 2 != 0) payload_chars.insert(payload_chars.size(), random_digit());
         pick = $urandom_range(99);
         if (pick < 15) begin
            payload_chars[$urandom_range(payload_chars.size() - 1)] = 8'($urandom_range(255));
         end else if (pick < 25 && payload_chars.size() > 1) begin
            void'(payload_chars.pop_back());
         end else if (pick < 32) begin
            payload_chars.insert($urandom_range(payload_chars.size()), 8'($urandom_range(255)));
         end
         for (i = 0; i < payload_chars.size(); i++) begin
            send_char(payload_chars[i], i == payload_chars.size() - 1);
         end
         sent += payload_chars.size();
      end
   endtask

   initial begin
      clear_payload_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hex_pairs();
      test_runs();
      test_bad_count();
      test_bad_hex();
      test_random(0, 0, 75);
      test_random(74, 0, 75);
      test_random(0, 74, 75);
      test_random(34, 34, 75);
      req_valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d payloads (%0d characters) under four idling patterns.",
               payloads_sent, chars_sent);
      $display("Checked %0d data bytes; status ok %0d, bad count %0d, bad hex %0d, odd %0d.",
               bytes_checked, status_seen[rhd_pkg::ST_OK], status_seen[rhd_pkg::ST_BAD_COUNT],
               status_seen[rhd_pkg::ST_BAD_HEX], status_seen[rhd_pkg::ST_ODD]);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
